// ===== rtl/core/rail_fence_transposer_assert.svh =====
// assertion macros shared by the rail fence transposer
// each macro expects a clock named clk and an active-high reset named rst in scope
`ifndef RAIL_FENCE_TRANSPOSER_ASSERT_SVH
`define RAIL_FENCE_TRANSPOSER_ASSERT_SVH

// same-cycle implication
`define RFT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rail fence transposer check failed");

// next-cycle implication
`define RFT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rail fence transposer check failed");

`endif

// ===== rtl/core/rft_pkg.sv =====
// ---------------------------------------------------------------------------
// rft_pkg
// Shared types and constants of the rail fence transposer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rft_pkg;

  localparam int BYTE_W  = 8;
  localparam int RAILS_W = 5;
  localparam int CFG_W   = 5;
  localparam int IDX_W   = 1;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_RAILS   = 1'b0;
  localparam logic [IDX_W-1:0] REG_DECRYPT = 1'b1;

  // status of the rail walker toward the sequencer
  typedef struct packed {
    logic valid;
    logic last;
  } walk_stat_t;

endpackage

// ===== rtl/core/rft_ram.sv =====
// ---------------------------------------------------------------------------
// rft_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/rft_rail_walk.sv =====
// ---------------------------------------------------------------------------
// rft_rail_walk
// Address generator: walks message positions rail by rail, one per cycle,
// adding a step to the position and comparing the sum against the length.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rft_rail_walk import rft_pkg::*; #(
  parameter int MAX_LEN   = 64,
  parameter int MAX_RAILS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [$clog2(MAX_RAILS+1)-1:0]     rails_in,
  input  logic [$clog2(MAX_LEN+1)-1:0]       len,
  output logic [$clog2(MAX_LEN)-1:0]         pos,
  output walk_stat_t                         stat
);

  localparam int RW = $clog2(MAX_RAILS + 1);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int SW = $clog2(2 * MAX_RAILS + MAX_LEN);

  logic          active;
  logic [RW-1:0] rail;
  logic [RW-1:0] nrails;
  logic [CW-1:0] len_q;
  logic [SW-1:0] period;
  logic          up;

  logic [SW-1:0] step;
  logic [SW-1:0] sum;
  logic [RW-1:0] rail_inc;
  logic          rail_end;
  logic          done;

  always_comb begin
    if (nrails == RW'(1)) begin
      step = SW'(1);
    end else if (rail == '0 || rail == nrails - RW'(1)) begin
      step = period;
    end else if (up) begin
      step = SW'(rail) << 1;
    end else begin
      step = period - (SW'(rail) << 1);
    end
    sum      = SW'(pos) + step;
    rail_end = (sum >= SW'(len_q));
    rail_inc = rail + RW'(1);
    done     = (rail_inc >= nrails) || (SW'(rail_inc) >= SW'(len_q));
  end

  assign stat.valid = active;
  assign stat.last  = active && rail_end && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
    end else if (active && rail_end && done) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pos    <= '0;
      rail   <= '0;
      up     <= 1'b0;
      nrails <= rails_in;
      len_q  <= len;
      period <= SW'(rails_in - RW'(1)) << 1;
    end else if (active) begin
      if (!rail_end) begin
        pos <= AW'(sum);
        up  <= !up;
      end else if (!done) begin
        // next rail starts at its own index, heading down first
        rail <= rail_inc;
        pos  <= AW'(rail_inc);
        up   <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/rail_fence_transposer.sv =====
// ---------------------------------------------------------------------------
// rail_fence_transposer
// Buffers a message and emits it in rail fence (zigzag) transposed order.
// ---------------------------------------------------------------------------
// Usage:
//   Input: a byte is taken at a clock edge with start high and busy low.
//   Bytes without in_last are buffered and busy stays low. A byte with
//   in_last ends the message (a byte dropped on a full buffer still ends it).
//   Config: cfg_we writes cfg_data into register cfg_index (0 rails,
//   1 decrypt_mode) at once; write only while busy is low and no result is
//   pending. Both are sampled when the last byte is taken.
//   Output: one result per buffered byte, each on out_byte/out_last/overflow
//   for one cycle with strobe high. The receiver cannot stall.
//   Flow: in encrypt busy stays high while the walker runs, and results
//   come one per cycle in walker order. Decrypt scatters into a second
//   buffer first, then gathers it in order. The rail walker hands out
//   one position per cycle and sets the pace.
//   Reset: synchronous; empties the buffer and sets rails 2, encrypt mode.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rail_fence_transposer import rft_pkg::*; #(
  parameter int MAX_LEN   = 64,
  parameter int MAX_RAILS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_last,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output logic              strobe,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last,
  output logic              overflow
);

  localparam int RW = $clog2(MAX_RAILS + 1);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ENC   = 3'd1;
  localparam logic [2:0] S_SCAT  = 3'd2;
  localparam logic [2:0] S_GAP   = 3'd3;
  localparam logic [2:0] S_GATH  = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [RAILS_W-1:0] rails;
  logic               decrypt_mode;
  logic [CW-1:0]      fill_count;
  logic               overflow_seen;
  logic [CW-1:0]      msg_len;
  logic               msg_ovf;
  logic               msg_dec;
  logic [AW-1:0]      idx;

  logic               accept;
  logic               has_room;
  logic [CW-1:0]      len_now;
  logic [RW-1:0]      rails_eff;
  logic               walk_start;
  logic [AW-1:0]      walk_pos;
  walk_stat_t         walk;

  logic               scat_we;
  logic [AW-1:0]      scat_addr;
  logic               res_valid;
  logic               res_last;
  logic               idx_last;

  logic               store_re;
  logic [AW-1:0]      store_raddr;
  logic [BYTE_W-1:0]  store_rdata;
  logic               buf_re;
  logic [BYTE_W-1:0]  buf_rdata;

  assign accept   = start && !busy;
  assign has_room = (fill_count < CW'(MAX_LEN));
  assign len_now  = has_room ? fill_count + CW'(1) : fill_count;
  assign busy     = (state != S_IDLE);
  assign idx_last = (CW'(idx) == msg_len - CW'(1));

  always_comb begin
    if (rails == '0) begin
      rails_eff = RW'(1);
    end else if (int'(rails) > MAX_RAILS) begin
      rails_eff = RW'(MAX_RAILS);
    end else begin
      rails_eff = RW'(rails);
    end
  end

  assign walk_start = accept && in_last;

  rft_rail_walk #(
    .MAX_LEN   (MAX_LEN),
    .MAX_RAILS (MAX_RAILS)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .start    (walk_start),
    .rails_in (rails_eff),
    .len      (len_now),
    .pos      (walk_pos),
    .stat     (walk)
  );

  // encrypt gathers through the walker, decrypt reads the store in order
  assign store_re    = (state == S_ENC || state == S_SCAT) && walk.valid;
  assign store_raddr = (state == S_ENC) ? walk_pos : idx;

  rft_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (accept && has_room),
    .waddr (fill_count[AW-1:0]),
    .wdata (in_byte),
    .re    (store_re),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  assign buf_re = (state == S_GATH);

  rft_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_LEN)
  ) u_scatter (
    .clk   (clk),
    .we    (scat_we),
    .waddr (scat_addr),
    .wdata (store_rdata),
    .re    (buf_re),
    .raddr (idx),
    .rdata (buf_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (walk_start) begin
          state_next = decrypt_mode ? S_SCAT : S_ENC;
        end
      end
      S_ENC: begin
        if (walk.last) begin
          state_next = S_IDLE;
        end
      end
      S_SCAT: begin
        if (walk.last) begin
          state_next = S_GAP;
        end
      end
      S_GAP: begin
        state_next = S_GATH;
      end
      S_GATH: begin
        if (idx_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rails         <= RAILS_W'(2);
      decrypt_mode  <= 1'b0;
      fill_count    <= '0;
      overflow_seen <= 1'b0;
      scat_we       <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      scat_we   <= (state == S_SCAT) && walk.valid;
      res_valid <= ((state == S_ENC) && walk.valid) || (state == S_GATH);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RAILS:   rails        <= cfg_data[RAILS_W-1:0];
          REG_DECRYPT: decrypt_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        if (in_last) begin
          fill_count    <= '0;
          overflow_seen <= 1'b0;
        end else if (has_room) begin
          fill_count <= fill_count + CW'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (walk_start) begin
      msg_len <= len_now;
      msg_ovf <= overflow_seen || !has_room;
      msg_dec <= decrypt_mode;
    end
    // one index serves the in-order store read and the in-order gather
    if (walk_start || state == S_GAP) begin
      idx <= '0;
    end else if (store_re && state == S_SCAT) begin
      idx <= idx + AW'(1);
    end else if (state == S_GATH) begin
      idx <= idx + AW'(1);
    end
    scat_addr <= walk_pos;
    res_last  <= (state == S_ENC) ? walk.last : idx_last;
  end

  assign strobe   = res_valid;
  assign out_byte = msg_dec ? buf_rdata : store_rdata;
  assign out_last = res_last;
  assign overflow = msg_ovf;

  `include "rail_fence_transposer_assert.svh"

  // a message ends with a quiet cycle before the next can show up
  `RFT_ASSERT_NEXT(a_last_gap, strobe && out_last, !strobe)
  // results of one message come back to back with a steady overflow flag
  `RFT_ASSERT_NEXT(a_burst, strobe && !out_last, strobe && $stable(overflow))
  // a taken last byte always starts the output phase
  `RFT_ASSERT_NEXT(a_start_busy, start && !busy && in_last, busy)
  // the buffer count never runs past capacity
  `RFT_ASSERT_SAME(a_fill_bound, 1'b1, fill_count <= CW'(MAX_LEN))

endmodule

// ===== tb/rail_fence_transposer_checker.sv =====
// ---------------------------------------------------------------------------
// rail_fence_transposer_checker
// Watches the config port, the byte input and the result strobe of the rail
// fence transposer. It keeps its own message buffer and register copies,
// works out the permuted message on every last byte and compares each
// result, field by field, against the oldest predicted character.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rail_fence_transposer_checker import rft_pkg::*; #(
  parameter int MAX_LEN   = 64,
  parameter int MAX_RAILS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_last,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              strobe,
  input  logic [BYTE_W-1:0] out_byte,
  input  logic              out_last,
  input  logic              overflow,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
    logic              lost;
  } out_char_t;

  out_char_t           pending_chars[$];
  logic [BYTE_W-1:0]   msg_buf[MAX_LEN];
  int                  msg_len;
  logic                bytes_lost;
  logic [RAILS_W-1:0]  rails_reg;
  logic                decrypt_reg;

  function automatic int zigzag_rail(int pos, int nrails);
    int period;
    int m;
    if (nrails <= 1) return 0;
    period = 2 * (nrails - 1);
    m = pos % period;
    return (m < nrails) ? m : (period - m);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  // builds the output order rail by rail and queues the permuted message
  task automatic permute_message();
    int                nrails;
    int                k;
    int                order[MAX_LEN];
    logic [BYTE_W-1:0] permuted[MAX_LEN];
    out_char_t         oc;
    nrails = rails_reg;
    if (nrails == 0) nrails = 1;
    if (nrails > MAX_RAILS) nrails = MAX_RAILS;
    k = 0;
    for (int r = 0; r < nrails; r++)
      for (int p = 0; p < msg_len; p++)
        if (zigzag_rail(p, nrails) == r) begin
          order[k] = p;
          k++;
        end
    for (int i = 0; i < msg_len; i++) begin
      if (decrypt_reg) permuted[order[i]] = msg_buf[i];
      else permuted[i] = msg_buf[order[i]];
    end
    for (int i = 0; i < msg_len; i++) begin
      oc.value = permuted[i];
      oc.last  = (i + 1 == msg_len);
      oc.lost  = bytes_lost;
      pending_chars.insert(pending_chars.size(), oc);
    end
    msg_len    = 0;
    bytes_lost = 1'b0;
  endtask

  always @(posedge clk) begin
    out_char_t want;
    if (rst) begin
      pending_chars.delete();
      errors      = 0;
      msg_len     = 0;
      bytes_lost  = 1'b0;
      rails_reg   = 5'd2;
      decrypt_reg = 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_RAILS) rails_reg = cfg_data[RAILS_W-1:0];
        else if (cfg_index == REG_DECRYPT) decrypt_reg = cfg_data[0];
      end
      if (strobe) begin
        if (pending_chars.size() == 0) begin
          report_mismatch("result with nothing expected", int'(out_byte), 0);
        end else begin
          want = pending_chars.pop_front();
          if (out_byte !== want.value)
            report_mismatch("out_byte", int'(out_byte), int'(want.value));
          if (out_last !== want.last)
            report_mismatch("out_last", int'(out_last), int'(want.last));
          if (overflow !== want.lost)
            report_mismatch("overflow", int'(overflow), int'(want.lost));
        end
      end
      // input transfer
      if (start && !busy) begin
        if (msg_len < MAX_LEN) begin
          msg_buf[msg_len] = in_byte;
          msg_len++;
        end else begin
          bytes_lost = 1'b1;
        end
        if (in_last) permute_message();
      end
    end
    pending <= pending_chars.size();
  end

endmodule

// ===== tb/rail_fence_transposer_test.sv =====
// ---------------------------------------------------------------------------
// rail_fence_transposer_test
// Drives messages and register settings into the rail fence transposer:
// a directed set of short messages over the rail extremes and both modes,
// then random messages with random gaps, including one that overruns the
// buffer. The checker beside the block predicts and compares the results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rail_fence_transposer_test;
  import rft_pkg::*;

  localparam int TOTAL_ITEMS = 110;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_GUARD = 20000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [BYTE_W-1:0] in_byte = '0;
  logic              in_last = 1'b0;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              busy;
  logic              strobe;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic              overflow;
  int                errors;
  int                pending;
  int                sent_items = 0;
  bit                overrun_done = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rail_fence_transposer dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_byte(in_byte), .in_last(in_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .out_byte(out_byte), .out_last(out_last), .overflow(overflow)
  );

  rail_fence_transposer_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_byte(in_byte), .in_last(in_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .out_byte(out_byte), .out_last(out_last), .overflow(overflow),
    .errors(errors), .pending(pending)
  );

  // one byte transfer, called at a rising edge; returns at the accepting edge
  task automatic push_byte(input logic [BYTE_W-1:0] value, input logic last, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_byte <= value;
    in_last <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_items++;
  endtask

  // hold off until every predicted result is out and the block is quiet
  task automatic wait_drained();
    int guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk);
    while ((pending != 0 || busy) && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input logic [CFG_W-1:0] nrails, input logic dec);
    cfg_we    <= 1'b1;
    cfg_index <= REG_RAILS;
    cfg_data  <= nrails;
    @(posedge clk);
    cfg_index <= REG_DECRYPT;
    cfg_data  <= {(CFG_W-1)'($urandom_range(0, 15)), dec};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_message(input int len, input bit no_gaps);
    for (int i = 0; i < len; i++)
      push_byte(BYTE_W'($urandom_range(0, 255)), i == len - 1,
                no_gaps ? 0 : int'($urandom_range(0, 10)));
  endtask

  initial begin
    int               nmsg;
    int               len;
    logic [CFG_W-1:0] nrails;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: two rails, encrypt
    push_byte(8'h00, 1'b0, 0);
    push_byte(8'hFF, 1'b0, $urandom_range(0, 10));
    push_byte(8'h5A, 1'b1, 0);
    wait_drained();
    // single rail is the identity
    load_config(5'd1, 1'b0);
    push_byte(8'hA5, 1'b0, 0);
    push_byte(8'h3C, 1'b0, 0);
    push_byte(8'hC3, 1'b1, 0);
    wait_drained();
    // zero rails behave as one
    load_config(5'd0, 1'b1);
    push_byte(8'h81, 1'b0, $urandom_range(0, 10));
    push_byte(8'h7E, 1'b1, 0);
    wait_drained();
    load_config(5'd16, 1'b1);
    send_message(5, 1'b0);
    wait_drained();
    // rails beyond the maximum saturate
    load_config(5'd31, 1'b0);
    send_message(4, 1'b1);
    wait_drained();
    // message made of its last byte only
    load_config(5'd3, 1'b1);
    push_byte(8'hFF, 1'b1, 0);
    wait_drained();
    load_config(5'd2, 1'b1);
    send_message(4, 1'b0);
    wait_drained();

    while (sent_items < TOTAL_ITEMS) begin
      case ($urandom_range(0, 5))
        0: nrails = 5'd1;
        1: nrails = 5'd16;
        2: nrails = $urandom_range(0, 1) ? 5'd31 : 5'd0;
        default: nrails = CFG_W'($urandom_range(0, 31));
      endcase
      load_config(nrails, 1'($urandom_range(0, 1)));
      nmsg = $urandom_range(1, 4);
      for (int m = 0; m < nmsg; m++) begin
        if (!overrun_done && sent_items > 20) begin
          // overrun: the tail, last byte included, is dropped
          len = $urandom_range(65, 67);
          overrun_done = 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
          len = $urandom_range(20, 40);
        end else begin
          len = $urandom_range(1, 12);
        end
        send_message(len, $urandom_range(0, 2) == 0);
        if ($urandom_range(0, 3) == 0) wait_drained();
      end
      wait_drained();
    end

    wait_drained();
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
